>>> rtl/core/lqs_pkg.sv
// Package for the latency quartile statistics block: widths, codes, defaults.
// No dependencies; used by all files in rtl/core.
`timescale 1ns / 1ps

package lqs_pkg;

    localparam int LAT_W  = 32;   // latency sample width
    localparam int VAL_W  = 48;   // 32.16 fixed point values and counts
    localparam int FRAC_W = 16;   // fraction bits of fixed point values
    localparam int NUM_W  = 97;   // merge numerator: two 96-bit products summed
    localparam int DEN_W  = 49;   // merge denominator: run_count + n
    localparam int MUL_W  = 48;   // serial multiplier operand width

    localparam int SAMPLE_DEPTH_DEF = 1024;

    localparam logic [VAL_W-1:0] THRESH_RESET = 48'h0100_0000_0000;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OVFL  = 2'd2;

endpackage

>>> rtl/core/lqs_mul.sv
// Serial shift-add multiplier, one operand bit per cycle.
// Depends on lqs_pkg for operand widths.
`timescale 1ns / 1ps

module lqs_mul
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lqs_pkg::MUL_W-1:0]         a,
    input  logic [lqs_pkg::MUL_W-1:0]         b,
    output logic                              done,
    output logic [2*lqs_pkg::MUL_W-1:0]       product
);

    localparam int PW = 2 * lqs_pkg::MUL_W;
    localparam int CW = $clog2(lqs_pkg::MUL_W + 1);

    logic [PW-1:0]              acc_reg;
    logic [PW-1:0]              a_reg;
    logic [lqs_pkg::MUL_W-1:0]  b_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg  <= '0;
                a_reg    <= {{(PW-lqs_pkg::MUL_W){1'b0}}, a};
                b_reg    <= b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (b_reg[0])
                begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg   <= {a_reg[PW-2:0], 1'b0};
                b_reg   <= {1'b0, b_reg[lqs_pkg::MUL_W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(lqs_pkg::MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/core/lqs_div.sv
// Restoring divider, one quotient bit per cycle; shared by mean and merge.
// Depends on lqs_pkg for numerator and denominator widths.
`timescale 1ns / 1ps

module lqs_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lqs_pkg::NUM_W-1:0]    num,
    input  logic [lqs_pkg::DEN_W-1:0]    den,
    output logic                         done,
    output logic [lqs_pkg::NUM_W-1:0]    quot
);

    localparam int NW = lqs_pkg::NUM_W;
    localparam int DW = lqs_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   r_shift;
    logic [DW:0]   r_sub;
    logic          fits;

    always_comb
    begin
        r_shift = {r_reg[DW-1:0], q_reg[NW-1]};
        fits    = r_shift >= {1'b0, d_reg};
        r_sub   = r_shift - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                q_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                r_reg   <= fits ? r_sub : r_shift;
                q_reg   <= {q_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/core/latency_quartile_statistics.sv
// Top level of the latency quartile statistics block: sample store, close sequencer.
// Depends on lqs_pkg, lqs_mul and lqs_div.
`timescale 1ns / 1ps

// Add requests (operation 0) store one latency sample per cycle while idle into
// an on-chip sample memory of SAMPLE_DEPTH entries; samples past capacity are
// dropped. Erase requests (operation 2) clear the running totals. A close
// request (operation 1) stalls the input while the sequencer works: for every
// stored sample it reads that sample as a pivot, then sweeps every stored
// sample through the single read port, counting smaller and equal entries,
// which places the pivot in sorted order and yields the quartiles and median;
// the first sweep also forms the sum. The mean then takes one pass of the
// serial divider; then, unless the new running count reaches the threshold,
// which sets overflow status and clears the running totals, each of the four
// running values takes a merge of two serial multiplies and one divide. Two
// results follow, period statistics and then running totals (last set). Once
// the second result sits in the output register the block takes requests again.
// Configuration writes are always ready and take effect at once.

module latency_quartile_statistics
#(
    parameter int SAMPLE_DEPTH = lqs_pkg::SAMPLE_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [lqs_pkg::LAT_W-1:0]   latency,
    input  logic [lqs_pkg::LAT_W-1:0]   period_min,
    input  logic [lqs_pkg::LAT_W-1:0]   period_max,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lqs_pkg::VAL_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        part,
    output logic [lqs_pkg::VAL_W-1:0]   avg_value,
    output logic [lqs_pkg::VAL_W-1:0]   mid_value,
    output logic [lqs_pkg::VAL_W-1:0]   low_quart,
    output logic [lqs_pkg::VAL_W-1:0]   high_quart,
    output logic [lqs_pkg::VAL_W-1:0]   sample_total,
    output logic [lqs_pkg::LAT_W-1:0]   least,
    output logic [lqs_pkg::LAT_W-1:0]   greatest,
    output logic [1:0]                  status,
    output logic                        last
);

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int CW = $clog2(SAMPLE_DEPTH + 1);
    localparam int LW = lqs_pkg::LAT_W;
    localparam int VW = lqs_pkg::VAL_W;
    localparam int FW = lqs_pkg::FRAC_W;
    localparam int NW = lqs_pkg::NUM_W;
    localparam int DW = lqs_pkg::DEN_W;
    localparam int MW = lqs_pkg::MUL_W;
    localparam int SW = LW + CW;

    typedef enum logic [4:0] {
        S_IDLE, S_PIV_RD, S_PIV_WT, S_SCAN, S_DRAIN, S_EVAL,
        S_MEAN, S_MEAN_WT, S_CHECK, S_MUL1, S_MUL1_WT, S_MUL2, S_MUL2_WT,
        S_MDIV, S_MDIV_WT, S_EMIT0, S_EMIT1
    } state_t;

    // sample store
    logic [LW-1:0] mem [SAMPLE_DEPTH];
    logic [LW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic          vld_reg;
    logic [LW-1:0] pivot_reg;
    logic [CW-1:0] lt_reg;
    logic [CW-1:0] eq_reg;
    logic [SW-1:0] sum_reg;
    logic [LW-1:0] mean_reg, med_reg, lq_reg, hq_reg;
    logic [LW-1:0] pmin_reg, pmax_reg;
    logic [1:0]    stat_reg;
    logic [DW-1:0] tot_reg;
    logic [NW-1:0] acc_reg;
    logic [1:0]    m_reg;
    logic [VW-1:0] thr_reg;

    logic [VW-1:0] run_val_reg [4];
    logic [VW-1:0] run_count_reg;
    logic [LW-1:0] run_min_reg, run_max_reg;

    logic          out_valid_reg, part_reg, last_reg;
    logic [VW-1:0] avg_reg, mid_reg, lqo_reg, hqo_reg, total_reg;
    logic [LW-1:0] least_reg, greatest_reg;
    logic [1:0]    status_reg;

    logic          in_acc;
    logic          out_free;
    logic [CW-1:0] k_lo, k_mid, k_hi;
    logic [CW:0]   lt_eq;
    logic [DW-1:0] tot_next;
    logic [VW-1:0] old_val, new_val;

    logic          mul_start, mul_done;
    logic [MW-1:0] mul_a, mul_b;
    logic [2*MW-1:0] mul_p;
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quot;
    logic [DW-1:0] div_den;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // quantile targets: n/4, n/2, n - n/4 clamped to n-1
    always_comb
    begin
        k_lo  = n_reg >> 2;
        k_mid = n_reg >> 1;
        k_hi  = n_reg - (n_reg >> 2);
        if (k_hi > n_reg - 1'b1)
        begin
            k_hi = n_reg - 1'b1;
        end
        lt_eq    = {1'b0, lt_reg} + {1'b0, eq_reg};
        tot_next = {1'b0, run_count_reg} + DW'(n_reg);
    end

    always_comb
    begin
        old_val = run_val_reg[m_reg];
        case (m_reg)
            2'd0:    new_val = {{(VW-LW-FW){1'b0}}, mean_reg, {FW{1'b0}}};
            2'd1:    new_val = {{(VW-LW-FW){1'b0}}, med_reg, {FW{1'b0}}};
            2'd2:    new_val = {{(VW-LW-FW){1'b0}}, lq_reg, {FW{1'b0}}};
            default: new_val = {{(VW-LW-FW){1'b0}}, hq_reg, {FW{1'b0}}};
        endcase
    end

    assign rd_addr = (state_reg == S_PIV_RD) ? i_reg[AW-1:0] : j_reg;
    assign wr_en   = in_acc && (operation == lqs_pkg::OP_ADD) &&
                     (count_reg < CW'(SAMPLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= latency;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // serial arithmetic
    assign mul_start = (state_reg == S_MUL1) || (state_reg == S_MUL2);
    assign mul_a     = (state_reg == S_MUL1) ? old_val : new_val;
    assign mul_b     = (state_reg == S_MUL1) ? run_count_reg : MW'(n_reg);
    assign div_start = (state_reg == S_MEAN) || (state_reg == S_MDIV);
    assign div_num   = (state_reg == S_MEAN) ? NW'(sum_reg) : acc_reg;
    assign div_den   = (state_reg == S_MEAN) ? DW'(n_reg) : tot_reg;

    lqs_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    lqs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            vld_reg       <= 1'b0;
            pivot_reg     <= '0;
            lt_reg        <= '0;
            eq_reg        <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            med_reg       <= '0;
            lq_reg        <= '0;
            hq_reg        <= '0;
            pmin_reg      <= '0;
            pmax_reg      <= '0;
            stat_reg      <= lqs_pkg::ST_OK;
            tot_reg       <= '0;
            acc_reg       <= '0;
            m_reg         <= '0;
            thr_reg       <= lqs_pkg::THRESH_RESET;
            for (int k = 0; k < 4; k++)
            begin
                run_val_reg[k] <= '0;
            end
            run_count_reg <= '0;
            run_min_reg   <= '0;
            run_max_reg   <= '0;
            out_valid_reg <= 1'b0;
            part_reg      <= 1'b0;
            last_reg      <= 1'b0;
            avg_reg       <= '0;
            mid_reg       <= '0;
            lqo_reg       <= '0;
            hqo_reg       <= '0;
            total_reg     <= '0;
            least_reg     <= '0;
            greatest_reg  <= '0;
            status_reg    <= lqs_pkg::ST_OK;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // sweep compare, one sample per cycle
            if (vld_reg)
            begin
                if (rd_data_reg < pivot_reg)
                begin
                    lt_reg <= lt_reg + 1'b1;
                end
                if (rd_data_reg == pivot_reg)
                begin
                    eq_reg <= eq_reg + 1'b1;
                end
                if (i_reg == '0)
                begin
                    sum_reg <= sum_reg + SW'(rd_data_reg);
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (operation)
                            lqs_pkg::OP_ADD:
                            begin
                                if (wr_en)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            lqs_pkg::OP_ERASE:
                            begin
                                for (int k = 0; k < 4; k++)
                                begin
                                    run_val_reg[k] <= '0;
                                end
                                run_count_reg <= '0;
                                run_min_reg   <= '0;
                                run_max_reg   <= '0;
                            end
                            lqs_pkg::OP_CLOSE:
                            begin
                                n_reg     <= count_reg;
                                count_reg <= '0;
                                pmin_reg  <= period_min;
                                pmax_reg  <= period_max;
                                i_reg     <= '0;
                                sum_reg   <= '0;
                                if (count_reg == '0)
                                begin
                                    stat_reg  <= lqs_pkg::ST_EMPTY;
                                    state_reg <= S_EMIT0;
                                end
                                else
                                begin
                                    stat_reg  <= lqs_pkg::ST_OK;
                                    state_reg <= S_PIV_RD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PIV_RD:
                begin
                    state_reg <= S_PIV_WT;
                end
                S_PIV_WT:
                begin
                    pivot_reg <= rd_data_reg;
                    lt_reg    <= '0;
                    eq_reg    <= '0;
                    j_reg     <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    vld_reg <= 1'b1;
                    if (CW'(j_reg) == n_reg - 1'b1)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    vld_reg   <= 1'b0;
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    // pivot holds sorted positions lt .. lt+eq-1
                    if ((lt_reg <= k_lo) && ({1'b0, k_lo} < lt_eq))
                    begin
                        lq_reg <= pivot_reg;
                    end
                    if ((lt_reg <= k_mid) && ({1'b0, k_mid} < lt_eq))
                    begin
                        med_reg <= pivot_reg;
                    end
                    if ((lt_reg <= k_hi) && ({1'b0, k_hi} < lt_eq))
                    begin
                        hq_reg <= pivot_reg;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        state_reg <= S_MEAN;
                    end
                    else
                    begin
                        state_reg <= S_PIV_RD;
                    end
                end
                S_MEAN:
                begin
                    state_reg <= S_MEAN_WT;
                end
                S_MEAN_WT:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= div_quot[LW-1:0];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    tot_reg <= tot_next;
                    m_reg   <= '0;
                    if (tot_next >= {1'b0, thr_reg})
                    begin
                        stat_reg <= lqs_pkg::ST_OVFL;
                        for (int k = 0; k < 4; k++)
                        begin
                            run_val_reg[k] <= '0;
                        end
                        run_count_reg <= '0;
                        run_min_reg   <= '0;
                        run_max_reg   <= '0;
                        state_reg     <= S_EMIT0;
                    end
                    else
                    begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL1_WT;
                end
                S_MUL1_WT:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= {1'b0, mul_p};
                        state_reg <= S_MUL2;
                    end
                end
                S_MUL2:
                begin
                    state_reg <= S_MUL2_WT;
                end
                S_MUL2_WT:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= acc_reg + {1'b0, mul_p};
                        state_reg <= S_MDIV;
                    end
                end
                S_MDIV:
                begin
                    state_reg <= S_MDIV_WT;
                end
                S_MDIV_WT:
                begin
                    if (div_done)
                    begin
                        run_val_reg[m_reg] <= div_quot[VW-1:0];
                        if (m_reg == 2'd3)
                        begin
                            run_count_reg <= tot_reg[VW-1:0];
                            if (pmax_reg > run_max_reg)
                            begin
                                run_max_reg <= pmax_reg;
                            end
                            if ((pmin_reg != '0) &&
                                ((run_min_reg == '0) || (pmin_reg < run_min_reg)))
                            begin
                                run_min_reg <= pmin_reg;
                            end
                            state_reg <= S_EMIT0;
                        end
                        else
                        begin
                            m_reg     <= m_reg + 1'b1;
                            state_reg <= S_MUL1;
                        end
                    end
                end
                S_EMIT0:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        part_reg      <= 1'b0;
                        last_reg      <= 1'b0;
                        status_reg    <= stat_reg;
                        least_reg     <= pmin_reg;
                        greatest_reg  <= pmax_reg;
                        total_reg     <= VW'(n_reg);
                        if (stat_reg == lqs_pkg::ST_EMPTY)
                        begin
                            avg_reg <= '0;
                            mid_reg <= '0;
                            lqo_reg <= '0;
                            hqo_reg <= '0;
                        end
                        else
                        begin
                            avg_reg <= {{(VW-LW-FW){1'b0}}, mean_reg, {FW{1'b0}}};
                            mid_reg <= {{(VW-LW-FW){1'b0}}, med_reg, {FW{1'b0}}};
                            lqo_reg <= {{(VW-LW-FW){1'b0}}, lq_reg, {FW{1'b0}}};
                            hqo_reg <= {{(VW-LW-FW){1'b0}}, hq_reg, {FW{1'b0}}};
                        end
                        state_reg <= S_EMIT1;
                    end
                end
                S_EMIT1:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        part_reg      <= 1'b1;
                        last_reg      <= 1'b1;
                        status_reg    <= stat_reg;
                        avg_reg       <= run_val_reg[0];
                        mid_reg       <= run_val_reg[1];
                        lqo_reg       <= run_val_reg[2];
                        hqo_reg       <= run_val_reg[3];
                        total_reg     <= run_count_reg;
                        least_reg     <= run_min_reg;
                        greatest_reg  <= run_max_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign part         = part_reg;
    assign avg_value    = avg_reg;
    assign mid_value    = mid_reg;
    assign low_quart    = lqo_reg;
    assign high_quart   = hqo_reg;
    assign sample_total = total_reg;
    assign least        = least_reg;
    assign greatest     = greatest_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for latency_quartile_statistics: requests, predictor, result check.
// Depends on lqs_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_top;
    import lqs_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DEPTH      = SAMPLE_DEPTH_DEF;
    localparam int MAX_GAP    = 18;
    localparam int IDLE_LIMIT = 5_000_000;  // must outlast the sort of a full-store close
    localparam logic [VAL_W-1:0] THRESH_TOP = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]       op;
        logic [LAT_W-1:0] lat;
        logic [LAT_W-1:0] pmin;
        logic [LAT_W-1:0] pmax;
    } request_t;

    typedef struct {
        logic             part;
        logic [VAL_W-1:0] avg;
        logic [VAL_W-1:0] mid;
        logic [VAL_W-1:0] lq;
        logic [VAL_W-1:0] hq;
        logic [VAL_W-1:0] total;
        logic [LAT_W-1:0] least;
        logic [LAT_W-1:0] greatest;
        logic [1:0]       status;
        logic             last;
    } stats_t;

    logic clk, rst_n;
    logic in_valid, in_stall;
    logic [1:0] operation;
    logic [LAT_W-1:0] latency, period_min, period_max;
    logic cfg_valid, cfg_ready;
    logic [VAL_W-1:0] cfg_data;
    logic out_valid, out_stall;
    logic part, last;
    logic [VAL_W-1:0] avg_value, mid_value, low_quart, high_quart, sample_total;
    logic [LAT_W-1:0] least, greatest;
    logic [1:0] status;

    latency_quartile_statistics u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .latency(latency),
        .period_min(period_min), .period_max(period_max),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .part(part), .avg_value(avg_value), .mid_value(mid_value),
        .low_quart(low_quart), .high_quart(high_quart),
        .sample_total(sample_total), .least(least), .greatest(greatest),
        .status(status), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- shadow state of the block ----------------
    logic [LAT_W-1:0] shadow_store [DEPTH];
    int               shadow_fill;
    logic [VAL_W-1:0] tot_mean, tot_median, tot_lq, tot_hq, tot_count;
    logic [LAT_W-1:0] tot_min, tot_max;
    logic [VAL_W-1:0] threshold;

    request_t pending_q [$];   // requests not yet presented
    stats_t   stats_q   [$];   // expected results, oldest first

    int  errors, closes_seen, overflows_seen, empties_seen, drops_seen, results_seen;
    bit  calm;                 // phase without idling on either side
    int  idle_cycles;

    function automatic logic [VAL_W-1:0] blend(logic [VAL_W-1:0] old_v, logic [VAL_W-1:0] old_n,
                                               logic [VAL_W-1:0] new_v, logic [VAL_W-1:0] new_n);
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        num = NUM_W'(old_v) * NUM_W'(old_n) + NUM_W'(new_v) * NUM_W'(new_n);
        den = NUM_W'(old_n) + NUM_W'(new_n);
        return VAL_W'(num / den);
    endfunction

    task automatic clear_totals();
        tot_mean = '0; tot_median = '0; tot_lq = '0; tot_hq = '0;
        tot_count = '0; tot_min = '0; tot_max = '0;
    endtask

    // Work out what one accepted request does to the shadow state and its results.
    task automatic apply_request(logic [1:0] op, logic [LAT_W-1:0] lat,
                                 logic [LAT_W-1:0] pmin, logic [LAT_W-1:0] pmax);
        logic [LAT_W-1:0] sorted [$];
        logic [63:0]      sum;
        stats_t           per, run;
        int               n, hi_idx;
        logic [1:0]       st;
        n = shadow_fill;
        st = ST_OK;
        if (op == OP_ADD)
        begin
            if (shadow_fill < DEPTH)
            begin
                shadow_store[shadow_fill] = lat;
                shadow_fill++;
            end
            else
                drops_seen++;
        end
        else if (op == OP_ERASE)
            clear_totals();
        else if (op == OP_CLOSE)
        begin
            closes_seen++;
            if (n == 0)
            begin
                st = ST_EMPTY;
                empties_seen++;
            end
            else
            begin
                sum = '0;
                for (int i = 0; i < n; i++)
                begin
                    sorted.push_back(shadow_store[i]);
                    sum += shadow_store[i];
                end
                sorted.sort();
                hi_idx = n - n / 4;
                if (hi_idx > n - 1)
                    hi_idx = n - 1;
                per.avg = VAL_W'(sum / n) << FRAC_W;
                per.mid = VAL_W'(sorted[n / 2]) << FRAC_W;
                per.lq  = VAL_W'(sorted[n / 4]) << FRAC_W;
                per.hq  = VAL_W'(sorted[hi_idx]) << FRAC_W;
                // threshold test uses a carry bit so a full count cannot wrap
                if ({1'b0, tot_count} + (VAL_W+1)'(n) >= {1'b0, threshold})
                begin
                    st = ST_OVFL;
                    overflows_seen++;
                    clear_totals();
                end
                else
                begin
                    tot_mean   = blend(tot_mean,   tot_count, per.avg, n);
                    tot_median = blend(tot_median, tot_count, per.mid, n);
                    tot_lq     = blend(tot_lq,     tot_count, per.lq,  n);
                    tot_hq     = blend(tot_hq,     tot_count, per.hq,  n);
                    tot_count  = tot_count + n;
                    if (pmax > tot_max)
                        tot_max = pmax;
                    if (pmin != 0 && (tot_min == 0 || pmin < tot_min))
                        tot_min = pmin;
                end
            end
            if (n == 0)
            begin
                per.avg = '0; per.mid = '0; per.lq = '0; per.hq = '0;
            end
            per.part = 1'b0; per.total = n; per.least = pmin; per.greatest = pmax;
            per.status = st; per.last = 1'b0;
            run.part = 1'b1; run.avg = tot_mean; run.mid = tot_median; run.lq = tot_lq;
            run.hq = tot_hq; run.total = tot_count; run.least = tot_min;
            run.greatest = tot_max; run.status = st; run.last = 1'b1;
            stats_q.push_back(per);
            stats_q.push_back(run);
            shadow_fill = 0;
        end
        // the unused code leaves everything alone
    endtask

    // ---------------- request driver ----------------
    request_t next_req;
    bit       req_held;
    int       send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            operation  <= OP_ADD;
            latency    <= '0;
            period_min <= '0;
            period_max <= '0;
            send_gap   = 0;
        end
        else
        begin
            req_held = in_valid;
            if (in_valid && !in_stall)
            begin
                apply_request(operation, latency, period_min, period_max);
                req_held = 1'b0;
            end
            if (!req_held)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_q.size() > 0)
                begin
                    next_req   = pending_q.pop_front();
                    operation  <= next_req.op;
                    latency    <= next_req.lat;
                    period_min <= next_req.pmin;
                    period_max <= next_req.pmax;
                    req_held   = 1'b1;
                    send_gap   = calm ? 0 : $urandom_range(0, MAX_GAP);
                end
            end
            in_valid <= req_held;
        end
    end

    // ---------------- result monitor ----------------
    int     stall_left;
    stats_t got, want;

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got.part = part; got.avg = avg_value; got.mid = mid_value;
                got.lq = low_quart; got.hq = high_quart; got.total = sample_total;
                got.least = least; got.greatest = greatest; got.status = status;
                got.last = last;
                if (stats_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, part %0d status %0d",
                             $time, got.part, got.status);
                end
                else
                begin
                    want = stats_q.pop_front();
                    check_field("part",         want.part,     got.part);
                    check_field("avg_value",    want.avg,      got.avg);
                    check_field("mid_value",    want.mid,      got.mid);
                    check_field("low_quart",    want.lq,       got.lq);
                    check_field("high_quart",   want.hq,       got.hq);
                    check_field("sample_total", want.total,    got.total);
                    check_field("least",        want.least,    got.least);
                    check_field("greatest",     want.greatest, got.greatest);
                    check_field("status",       want.status,   got.status);
                    check_field("last",         want.last,     got.last);
                end
                stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // ---------------- watchdog: cycles with no handshake at all ----------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, stats_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [LAT_W-1:0] pick_latency();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 15);      // many duplicates
            2:       return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: return $urandom_range(0, 100000);
        endcase
    endfunction

    task automatic push(logic [1:0] op, logic [LAT_W-1:0] lat,
                        logic [LAT_W-1:0] pmin, logic [LAT_W-1:0] pmax);
        request_t r;
        r.op = op; r.lat = lat; r.pmin = pmin; r.pmax = pmax;
        pending_q.push_back(r);
    endtask

    task automatic push_period(int n);
        for (int i = 0; i < n; i++)
        begin
            push(OP_ADD, pick_latency(), $urandom, $urandom);
            if ($urandom_range(0, 40) == 0)
                push($urandom_range(0, 1) ? OP_ERASE : OP_UNUSED, $urandom, $urandom, $urandom);
        end
        push(OP_CLOSE, $urandom,
             ($urandom_range(0, 3) == 0) ? 32'd0 : pick_latency(), pick_latency());
    endtask

    // Sender holds off until every expected result has come, then lets the
    // block settle before any register write.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || stats_q.size() != 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_threshold(logic [VAL_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        threshold = v;
        cfg_valid <= 1'b0;
    endtask

    int random_items;

    initial
    begin
        errors = 0; closes_seen = 0; overflows_seen = 0; empties_seen = 0;
        drops_seen = 0; results_seen = 0; idle_cycles = 0; calm = 1'b0;
        shadow_fill = 0; threshold = THRESH_RESET;
        clear_totals();
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty close, field extremes, pmin of zero, erase, unused code,
        // small periods where the upper quartile index is clamped.
        push(OP_CLOSE, 32'd0, 32'd0, 32'hFFFF_FFFF);
        push(OP_CLOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        push(OP_ADD, 32'hFFFF_FFFF, 32'd0, 32'd0);
        push(OP_CLOSE, 32'd0, 32'd0, 32'hFFFF_FFFF);
        push(OP_ADD, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(OP_ADD, 32'hFFFF_FFFF, 32'd0, 32'd0);
        push(OP_CLOSE, 32'd0, 32'd5, 32'd9);
        push(OP_UNUSED, 32'd7, 32'd7, 32'd7);
        push(OP_ADD, 32'd3, 32'd0, 32'd0);
        push(OP_ADD, 32'd1, 32'd0, 32'd0);
        push(OP_ADD, 32'd2, 32'd0, 32'd0);
        push(OP_CLOSE, 32'd0, 32'd1, 32'd3);
        push(OP_ADD, 32'd8, 32'd0, 32'd0);
        push(OP_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(OP_ADD, 32'd6, 32'd0, 32'd0);
        push(OP_ADD, 32'd6, 32'd0, 32'd0);
        push(OP_ADD, 32'd4, 32'd0, 32'd0);
        push(OP_CLOSE, 32'd0, 32'd4, 32'd8);
        push_period(5);
        drain();

        // Threshold at its floor: every nonempty close overflows.
        write_threshold(48'd1);
        push_period(1);
        push_period(0);
        push_period(3);
        drain();

        // Threshold at its ceiling, with one period that overfills the store.
        write_threshold(THRESH_TOP);
        calm = 1'b1;
        for (int i = 0; i < DEPTH + 6; i++)
            push(OP_ADD, pick_latency(), 32'd0, 32'd0);
        push(OP_CLOSE, 32'd0, 32'd1, 32'hFFFF_FFFF);
        drain();
        calm = 1'b0;

        // Random phases: mostly small periods, thresholds from tiny to huge.
        random_items = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:       write_threshold($urandom_range(10, 300));
                1:       write_threshold(VAL_W'({$urandom, $urandom}));
                2:       write_threshold(THRESH_RESET);
                default: write_threshold($urandom_range(2, 40));
            endcase
            calm = (ph == 5);
            while (pending_q.size() < 80)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2: push_period(0);
                    3, 4:    push_period($urandom_range(13, 40));
                    5:       push_period($urandom_range(41, 70));
                    default: push_period($urandom_range(1, 12));
                endcase
            end
            random_items += pending_q.size();
            drain();
        end

        $display("Run: %0d closes (%0d empty, %0d overflow), %0d results, %0d dropped samples",
                 closes_seen, empties_seen, overflows_seen, results_seen, drops_seen);
        $display("Thresholds 1 .. 2^48-1, plus %0d random requests", random_items);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> latency_quartile_statistics.f
rtl/core/lqs_pkg.sv
rtl/core/lqs_mul.sv
rtl/core/lqs_div.sv
rtl/core/latency_quartile_statistics.sv
sim/tb_top.sv
